@@ design/ogud_pkg.sv @@
// Shared types, constants and defaults for the occupancy grid update and decay unit.
package ogud_pkg;

  // Default grid dimensions
  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;

  // Cell index width covers the largest supported grid (4096 cells per axis)
  localparam int IDX_W  = 12;
  // Width of a clamped in-use size (0..4096)
  localparam int USED_W = 13;

  // Depth of the command and result queues
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_EDGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_EDGE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y        = 3'd5;

  // Register reset values
  localparam logic [31:0] INV_CELL_EDGE_RST = 32'd655360;
  localparam logic [31:0] CELL_EDGE_RST     = 32'd6554;
  localparam logic [8:0]  SIZE_RST          = 9'd256;

  // Request type codes
  localparam logic [1:0] REQ_STATIC = 2'd0;
  localparam logic [1:0] REQ_DECAY  = 2'd1;
  localparam logic [1:0] REQ_LASER  = 2'd2;

  // Classified command kinds
  typedef enum logic [1:0] {
    K_NONE,
    K_STATIC,
    K_DECAY,
    K_LASER
  } kind_t;

  // Command from front to back end
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iy;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic               new_obstacle;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
  } res_t;

endpackage

@@ design/occupancy_grid_update_decay_unit.sv @@
// Top level of the occupancy grid update and decay unit: registers, queues, front and back end.
// Every request gives exactly one result, in request order. The front end takes one request at
// a time: static and decay requests pass straight on, while a laser point is binned by its shared
// 32x32 multiplier, x then y. The back end owns the single-port grid memory and reads each cell
// before it writes it back: a static request or a laser point touches its own cell (on a laser hit
// the centre multiplier then runs x then y), and a decay tick walks every cell of the in-use area.
// After reset the back end clears the whole grid, rounded up to powers of two per axis, and full
// stays high meanwhile; configuration writes are taken at any time and must be made while the
// unit is idle.
module occupancy_grid_update_decay_unit #(
  parameter int GRID_X = ogud_pkg::GRID_X_DEF,
  parameter int GRID_Y = ogud_pkg::GRID_Y_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request side
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     req_type,
  input  logic signed [31:0]             point_x,
  input  logic signed [31:0]             point_y,
  input  logic [7:0]                     cell_x,
  input  logic [7:0]                     cell_y,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic                           new_obstacle,
  output logic signed [31:0]             centre_x,
  output logic signed [31:0]             centre_y,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ogud_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic signed [31:0]          origin_x;
  logic signed [31:0]          origin_y;
  logic [31:0]                 inv_cell_edge;
  logic [31:0]                 cell_edge;
  logic [8:0]                  size_x;
  logic [8:0]                  size_y;
  logic [ogud_pkg::USED_W-1:0] ux;
  logic [ogud_pkg::USED_W-1:0] uy;

  ogud_pkg::cmd_t front_cmd;
  ogud_pkg::cmd_t back_cmd;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  ogud_pkg::res_t back_res;
  ogud_pkg::res_t out_res;
  logic           res_push;
  logic           res_full;
  logic           clear_busy;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_cell_edge <= ogud_pkg::INV_CELL_EDGE_RST;
      cell_edge     <= ogud_pkg::CELL_EDGE_RST;
      size_x        <= ogud_pkg::SIZE_RST;
      size_y        <= ogud_pkg::SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ogud_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        ogud_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        ogud_pkg::REG_INV_CELL_EDGE: inv_cell_edge <= cfg_data;
        ogud_pkg::REG_CELL_EDGE:     cell_edge     <= cfg_data;
        ogud_pkg::REG_SIZE_X:        size_x        <= cfg_data[8:0];
        ogud_pkg::REG_SIZE_Y:        size_y        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // in-use sizes clamped to the grid
  assign ux = ({4'd0, size_x} > ogud_pkg::USED_W'(GRID_X)) ?
              ogud_pkg::USED_W'(GRID_X) : {4'd0, size_x};
  assign uy = ({4'd0, size_y} > ogud_pkg::USED_W'(GRID_Y)) ?
              ogud_pkg::USED_W'(GRID_Y) : {4'd0, size_y};

  ogud_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .point_x       (point_x),
    .point_y       (point_y),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .inv_cell_edge (inv_cell_edge),
    .ux            (ux),
    .uy            (uy),
    .clear_busy    (clear_busy),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd           (front_cmd)
  );

  ogud_fifo #(
    .W     ($bits(ogud_pkg::cmd_t)),
    .DEPTH (ogud_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  ogud_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd        (back_cmd),
    .ux         (ux),
    .uy         (uy),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .cell_edge  (cell_edge),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res),
    .clear_busy (clear_busy)
  );

  ogud_fifo #(
    .W     ($bits(ogud_pkg::res_t)),
    .DEPTH (ogud_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign new_obstacle = out_res.new_obstacle;
  assign centre_x     = out_res.centre_x;
  assign centre_y     = out_res.centre_y;

`ifndef SYNTHESIS
  // no request taken while the grid is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> full)
    else $error("request side open during grid clear");

  // no result can exist while the grid is being cleared
  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> empty)
    else $error("result present during grid clear");

  // an accepted request occupies the front end on the next cycle
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front end took a request without going busy");
`endif

endmodule

@@ design/ogud_fifo.sv @@
// Small register queue used between front end, back end and result port.
module ogud_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/ogud_front.sv @@
// Front end: accepts requests, bins laser points into cells and classifies commands.
module ogud_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type,
  input  logic signed [31:0]          point_x,
  input  logic signed [31:0]          point_y,
  input  logic [7:0]                  cell_x,
  input  logic [7:0]                  cell_y,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic [31:0]                 inv_cell_edge,
  input  logic [ogud_pkg::USED_W-1:0] ux,
  input  logic [ogud_pkg::USED_W-1:0] uy,
  input  logic                        clear_busy,
  input  logic                        cmd_full,
  output logic                        cmd_push,
  output ogud_pkg::cmd_t              cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_CHECK,
    S_PUSH
  } state_t;

  state_t             state;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [63:0]        prod;
  logic [31:0]        ix_q;
  ogud_pkg::cmd_t     cmd_q;

  logic signed [32:0] dx_next;
  logic signed [32:0] dy_next;
  logic [31:0]        mul_a;
  logic [63:0]        prod_next;
  logic [31:0]        iy_w;
  logic               accept;
  logic               static_ok;
  logic               laser_ok;

  assign full     = (state != S_IDLE) || clear_busy;
  assign accept   = push && !full;
  assign cmd_push = (state == S_PUSH) && !cmd_full;
  assign cmd      = cmd_q;

  // offsets from the origin, exact in 33 bits
  assign dx_next = {point_x[31], point_x} - {origin_x[31], origin_x};
  assign dy_next = {point_y[31], point_y} - {origin_y[31], origin_y};

  // one shared 32x32 multiplier, x axis then y axis
  assign mul_a     = (state == S_MUL_X) ? dx[31:0] : dy[31:0];
  assign prod_next = {32'd0, mul_a} * {32'd0, inv_cell_edge};
  assign iy_w      = prod[63:32];

  assign static_ok = ({5'd0, cell_x} < ux) && ({5'd0, cell_y} < uy);
  assign laser_ok  = !dx[32] && (dx != '0) && !dy[32] && (dy != '0) &&
                     (ix_q != '0) && (iy_w != '0) &&
                     (ix_q < 32'(ux)) && (iy_w < 32'(uy));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dx       <= dx_next;
            dy       <= dy_next;
            cmd_q.ix <= ogud_pkg::IDX_W'(cell_x);
            cmd_q.iy <= ogud_pkg::IDX_W'(cell_y);
            unique case (req_type)
              ogud_pkg::REQ_STATIC: begin
                cmd_q.kind <= static_ok ? ogud_pkg::K_STATIC : ogud_pkg::K_NONE;
                state      <= S_PUSH;
              end
              ogud_pkg::REQ_DECAY: begin
                cmd_q.kind <= ogud_pkg::K_DECAY;
                state      <= S_PUSH;
              end
              ogud_pkg::REQ_LASER: begin
                state <= S_MUL_X;
              end
              default: begin
                cmd_q.kind <= ogud_pkg::K_NONE;
                state      <= S_PUSH;
              end
            endcase
          end
        end
        S_MUL_X: begin
          prod  <= prod_next;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          ix_q  <= prod[63:32];
          prod  <= prod_next;
          state <= S_CHECK;
        end
        S_CHECK: begin
          cmd_q.kind <= laser_ok ? ogud_pkg::K_LASER : ogud_pkg::K_NONE;
          cmd_q.ix   <= ix_q[ogud_pkg::IDX_W-1:0];
          cmd_q.iy   <= iy_w[ogud_pkg::IDX_W-1:0];
          state      <= S_PUSH;
        end
        S_PUSH: begin
          if (!cmd_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/ogud_back.sv @@
// Back end: owns the grid memory, clears it, applies commands and builds results.
module ogud_back #(
  parameter int GRID_X = ogud_pkg::GRID_X_DEF,
  parameter int GRID_Y = ogud_pkg::GRID_Y_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  ogud_pkg::cmd_t              cmd,
  input  logic [ogud_pkg::USED_W-1:0] ux,
  input  logic [ogud_pkg::USED_W-1:0] uy,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic [31:0]                 cell_edge,
  input  logic                        res_full,
  output logic                        res_push,
  output ogud_pkg::res_t              res,
  output logic                        clear_busy
);

  localparam int AXW = $clog2(GRID_X);
  localparam int AYW = $clog2(GRID_Y);
  localparam int AW  = AXW + AYW;
  localparam int CW  = ogud_pkg::IDX_W + 32;
  localparam int SW  = CW + 2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WR,
    S_MUL_X,
    S_MUL_Y,
    S_CEN_Y,
    S_DRD,
    S_DWR,
    S_RES
  } state_t;

  // each entry: static mark over 7-bit occupancy
  logic [7:0] grid [2**AW];

  state_t                    state;
  logic [AW-1:0]             clr_addr;
  ogud_pkg::cmd_t            cmd_q;
  logic [ogud_pkg::IDX_W-1:0] i_cnt;
  logic [ogud_pkg::IDX_W-1:0] j_cnt;
  logic [7:0]                rd_data;
  logic [CW-1:0]             cprod;
  ogud_pkg::res_t            res_q;

  logic [AW-1:0]             addr;
  logic                      we;
  logic [7:0]                wd;
  logic [6:0]                occ;
  logic [ogud_pkg::IDX_W-1:0] cmul_a;
  logic [CW-1:0]             cprod_next;
  logic signed [31:0]        cen_org;
  logic signed [SW-1:0]      cen_sum;
  logic signed [31:0]        cen_sat;
  logic                      hit;

  assign occ        = rd_data[6:0];
  assign clear_busy = (state == S_CLEAR);
  assign cmd_pop    = (state == S_IDLE) && !cmd_empty;
  assign res_push   = (state == S_RES) && !res_full;
  assign res        = res_q;
  assign hit        = (cmd_q.kind == ogud_pkg::K_LASER) && (occ <= 7'd50);

  // grid address select
  always_comb begin
    case (state) inside
      S_CLEAR:      addr = clr_addr;
      S_DRD, S_DWR: addr = {i_cnt[AXW-1:0], j_cnt[AYW-1:0]};
      default:      addr = {cmd_q.ix[AXW-1:0], cmd_q.iy[AYW-1:0]};
    endcase
  end

  // write-back decision
  always_comb begin
    we = 1'b0;
    wd = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_WR: begin
        if (cmd_q.kind == ogud_pkg::K_STATIC) begin
          we = (occ == '0);
          wd = {1'b1, 7'd1};
        end else begin
          we = hit;
          wd = {rd_data[7], 7'd100};
        end
      end
      S_DWR: begin
        we = !rd_data[7] && (occ != '0);
        wd = {1'b0, occ - 7'd1};
      end
      default: ;
    endcase
  end

  // grid memory, one port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      grid[addr] <= wd;
    end
    rd_data <= grid[addr];
  end

  // centre: idx * cell_edge + cell_edge / 2 + origin, then saturate
  assign cmul_a     = (state == S_MUL_X) ? cmd_q.ix : cmd_q.iy;
  assign cprod_next = CW'(cmul_a) * CW'(cell_edge);
  assign cen_org    = (state == S_MUL_Y) ? origin_x : origin_y;
  assign cen_sum    = $signed({2'b00, cprod}) +
                      $signed({{(SW-31){1'b0}}, cell_edge[31:1]}) +
                      $signed({{(SW-32){cen_org[31]}}, cen_org});

  always_comb begin
    if (cen_sum[SW-1:31] == '0 || cen_sum[SW-1:31] == '1) begin
      cen_sat = cen_sum[31:0];
    end else if (cen_sum[SW-1]) begin
      cen_sat = 32'sh8000_0000;
    end else begin
      cen_sat = 32'sh7fff_ffff;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd_q <= cmd;
            res_q <= '0;
            i_cnt <= '0;
            j_cnt <= '0;
            unique case (cmd.kind) inside
              ogud_pkg::K_STATIC, ogud_pkg::K_LASER: state <= S_RD;
              ogud_pkg::K_DECAY: begin
                state <= (ux == '0 || uy == '0) ? S_RES : S_DRD;
              end
              default: state <= S_RES;
            endcase
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (hit) begin
            res_q.new_obstacle <= 1'b1;
            state              <= S_MUL_X;
          end else begin
            state <= S_RES;
          end
        end
        S_MUL_X: begin
          cprod <= cprod_next;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          res_q.centre_x <= cen_sat;
          cprod          <= cprod_next;
          state          <= S_CEN_Y;
        end
        S_CEN_Y: begin
          res_q.centre_y <= cen_sat;
          state          <= S_RES;
        end
        S_DRD: state <= S_DWR;
        S_DWR: begin
          if (ogud_pkg::USED_W'(j_cnt) + 1'b1 == uy) begin
            j_cnt <= '0;
            if (ogud_pkg::USED_W'(i_cnt) + 1'b1 == ux) begin
              state <= S_RES;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              state <= S_DRD;
            end
          end else begin
            j_cnt <= j_cnt + 1'b1;
            state <= S_DRD;
          end
        end
        S_RES: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the occupancy grid update and decay unit.
`timescale 1ns / 1ps

module tb;

  localparam int NCELL = 256;
  localparam int WDOG_LIMIT = 600000;
  localparam logic [1:0] REQ_NOP = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [7:0]         cx;
    logic [7:0]         cy;
  } grid_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] req_type = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic [7:0] cell_x = '0;
  logic [7:0] cell_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic new_obstacle;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ogud_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  occupancy_grid_update_decay_unit dut (.*);

  always #1 clk = ~clk;

  // Grid mirror and register copies
  logic [6:0] occ_mirror [NCELL*NCELL];
  logic       static_mirror [NCELL*NCELL];
  longint          org_x, org_y;
  longint unsigned inv_cs, cs;
  int unsigned     sx_reg, sy_reg;

  grid_req_t       pend_reqs [$];
  ogud_pkg::res_t  owed_results [$];
  grid_req_t       cur_req;
  int              errors = 0;
  bit              calm = 0;

  function automatic void add_req(grid_req_t r);
    pend_reqs.insert(pend_reqs.size(), r);
  endfunction

  function automatic int unsigned used_x();
    return sx_reg > NCELL ? NCELL : sx_reg;
  endfunction

  function automatic int unsigned used_y();
    return sy_reg > NCELL ? NCELL : sy_reg;
  endfunction

  function automatic longint unsigned bin_cell(logic signed [31:0] p, longint org);
    longint d;
    d = longint'(p) - org;
    if (d <= 0) return 0;
    return (longint'(unsigned'(d)) * inv_cs) >> 32;
  endfunction

  function automatic logic signed [31:0] cell_centre(longint unsigned idx, longint org);
    longint c;
    c = longint'(idx * cs) + longint'(cs >> 1) + org;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c[31:0];
  endfunction

  // Apply one accepted request to the mirror and queue its result
  function automatic void grid_update(grid_req_t r);
    ogud_pkg::res_t res;
    int unsigned ux, uy, k;
    longint unsigned ix, iy;
    ux = used_x();
    uy = used_y();
    res = '0;
    case (r.kind)
      ogud_pkg::REQ_STATIC: begin
        if (r.cx < ux && r.cy < uy) begin
          k = r.cx * NCELL + r.cy;
          if (occ_mirror[k] == 0) begin
            occ_mirror[k] = 7'd1;
            static_mirror[k] = 1'b1;
          end
        end
      end
      ogud_pkg::REQ_DECAY: begin
        for (int i = 0; i < ux; i++)
          for (int j = 0; j < uy; j++) begin
            k = i * NCELL + j;
            if (!static_mirror[k] && occ_mirror[k] > 0) occ_mirror[k]--;
          end
      end
      ogud_pkg::REQ_LASER: begin
        ix = bin_cell(r.px, org_x);
        iy = bin_cell(r.py, org_y);
        if (ix > 0 && iy > 0 && ix < ux && iy < uy) begin
          k = 32'(ix * NCELL + iy);
          if (occ_mirror[k] <= 50) begin
            occ_mirror[k] = 7'd100;
            res.new_obstacle = 1'b1;
            res.centre_x = cell_centre(ix, org_x);
            res.centre_y = cell_centre(iy, org_y);
          end
        end
      end
      default: ;
    endcase
    owed_results.insert(owed_results.size(), res);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) grid_update(cur_req);
      if (push && full) begin
        // hold the offered request
      end else if (pend_reqs.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        cur_req = pend_reqs.pop_front();
        push <= 1'b1;
        req_type <= cur_req.kind;
        point_x <= cur_req.px;
        point_y <= cur_req.py;
        cell_x <= cur_req.cx;
        cell_y <= cur_req.cy;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor with one long hold-off to back the unit up
  int  popped = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    ogud_pkg::res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        popped++;
        if (owed_results.size() == 0) begin
          $display("%0t unexpected result: actual %0b %0d %0d", $time, new_obstacle,
                   centre_x, centre_y);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (new_obstacle !== want.new_obstacle) begin
            $display("%0t new_obstacle: expected %0b actual %0b", $time,
                     want.new_obstacle, new_obstacle);
            errors++;
          end
          if (centre_x !== want.centre_x) begin
            $display("%0t centre_x: expected %0d actual %0d", $time, want.centre_x, centre_x);
            errors++;
          end
          if (centre_y !== want.centre_y) begin
            $display("%0t centre_y: expected %0d actual %0d", $time, want.centre_y, centre_y);
            errors++;
          end
        end
      end
      if (!hold_done && popped >= 600) begin
        hold_done = 1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [ogud_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ogud_pkg::REG_ORIGIN_X:      org_x = longint'(signed'(val));
      ogud_pkg::REG_ORIGIN_Y:      org_y = longint'(signed'(val));
      ogud_pkg::REG_INV_CELL_EDGE: inv_cs = 64'(val);
      ogud_pkg::REG_CELL_EDGE:     cs = 64'(val);
      ogud_pkg::REG_SIZE_X:        sx_reg = 32'(val[8:0]);
      ogud_pkg::REG_SIZE_Y:        sy_reg = 32'(val[8:0]);
      default: ;
    endcase
  endtask

  task automatic set_map(logic [31:0] ox, logic [31:0] oy, logic [31:0] inv,
                         logic [31:0] csz, logic [8:0] sx, logic [8:0] sy);
    write_reg(ogud_pkg::REG_ORIGIN_X, ox);
    write_reg(ogud_pkg::REG_ORIGIN_Y, oy);
    write_reg(ogud_pkg::REG_INV_CELL_EDGE, inv);
    write_reg(ogud_pkg::REG_CELL_EDGE, csz);
    write_reg(ogud_pkg::REG_SIZE_X, {23'd0, sx});
    write_reg(ogud_pkg::REG_SIZE_Y, {23'd0, sy});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pend_reqs.size() > 0 || push || owed_results.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic grid_req_t req(logic [1:0] k, logic signed [31:0] px,
                                    logic signed [31:0] py, logic [7:0] cx, logic [7:0] cy);
    grid_req_t r;
    r.kind = k; r.px = px; r.py = py; r.cx = cx; r.cy = cy;
    return r;
  endfunction

  // Coordinate landing near a chosen cell index along one axis, or else at a small random offset from the origin
  function automatic logic signed [31:0] aim(longint org, int unsigned used);
    longint d, p;
    if (inv_cs == 0 || $urandom_range(9) == 0)
      d = longint'($urandom_range(2000)) - 1000;
    else
      d = longint'(((longint'($urandom_range(used)) << 32) + $urandom) / inv_cs);
    p = org + d;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic grid_req_t rand_req(bit decay_ok);
    int unsigned r, ux, uy;
    logic [7:0] cx, cy;
    ux = used_x();
    uy = used_y();
    r = $urandom_range(99);
    cx = 8'($urandom);
    cy = 8'($urandom);
    if (ux > 0 && uy > 0 && $urandom_range(4) != 0) begin
      cx = 8'($urandom_range(ux - 1));
      cy = 8'($urandom_range(uy - 1));
    end
    if (r < 15 && decay_ok) return req(ogud_pkg::REQ_DECAY, $urandom, $urandom, cx, cy);
    if (r < 18) return req(REQ_NOP, $urandom, $urandom, cx, cy);
    if (r < 38) return req(ogud_pkg::REQ_STATIC, $urandom, $urandom, cx, cy);
    if (r < 48) return req(ogud_pkg::REQ_LASER, $urandom, $urandom, cx, cy);
    return req(ogud_pkg::REQ_LASER, aim(org_x, ux), aim(org_y, uy), cx, cy);
  endfunction

  initial begin
    int unsigned sx, sy, pick;
    logic [31:0] ox, oy, inv, csz;
    for (int k = 0; k < NCELL * NCELL; k++) begin
      occ_mirror[k] = '0;
      static_mirror[k] = 1'b0;
    end
    org_x = 0; org_y = 0;
    inv_cs = 64'(ogud_pkg::INV_CELL_EDGE_RST); cs = 64'(ogud_pkg::CELL_EDGE_RST);
    sx_reg = 32'(ogud_pkg::SIZE_RST); sy_reg = 32'(ogud_pkg::SIZE_RST);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: 10 cells per metre
    add_req(req(ogud_pkg::REQ_STATIC, 0, 0, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_STATIC, 0, 0, 8'd255, 8'd255));
    add_req(req(ogud_pkg::REQ_STATIC, 0, 0, 8'd5, 8'd5));
    add_req(req(ogud_pkg::REQ_STATIC, 0, 0, 8'd5, 8'd5));
    // laser on a static cell, then again on the now full cell
    add_req(req(ogud_pkg::REQ_LASER, 32'sd36045, 32'sd36045, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'sd36045, 32'sd36045, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_STATIC, 0, 0, 8'd5, 8'd5));
    // cell zero on each axis, negative offsets, out of range
    add_req(req(ogud_pkg::REQ_LASER, 32'sd3000, 32'sd36045, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'sd36045, 32'sd3000, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, -32'sd36045, 32'sd36045, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'h7FFFFFFF, 32'h7FFFFFFF, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'h80000000, 32'h80000000, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'sd1000000, 32'sd1600000, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'sd1671000, 32'sd1671000, 8'd0, 8'd0));
    add_req(req(REQ_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF));
    add_req(req(ogud_pkg::REQ_STATIC, 32'h55555555, 32'hAAAAAAAA, 8'hAA, 8'h55));
    // one sweep over the whole grid
    add_req(req(ogud_pkg::REQ_DECAY, 0, 0, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'sd1000000, 32'sd1600000, 8'd0, 8'd0));
    wait_drained();

    // No cell in use
    set_map(32'd0, 32'd0, ogud_pkg::INV_CELL_EDGE_RST, ogud_pkg::CELL_EDGE_RST, 9'd0, 9'd0);
    add_req(req(ogud_pkg::REQ_STATIC, 0, 0, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_DECAY, 0, 0, 8'd0, 8'd0));
    add_req(req(ogud_pkg::REQ_LASER, 32'sd36045, 32'sd36045, 8'd0, 8'd0));
    wait_drained();

    // Random phases, mostly small grids so sweeps stay short
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 4);
      pick = $urandom_range(9);
      sx = $urandom_range(1, 16);
      sy = $urandom_range(1, 16);
      ox = $urandom_range(200000) - 100000;
      oy = $urandom_range(200000) - 100000;
      inv = $urandom_range(1 << 12, 1 << 21);
      csz = $urandom_range(1 << 10, 1 << 20);
      case (ph)
        1: begin ox = 32'h80000000; oy = 32'h7FFFFFFF; inv = 32'hFFFFFFFF;
                 csz = 32'hFFFFFFFF; end
        2: begin ox = 32'h7FFF0000; oy = 32'h80000000; inv = 32'd0; csz = 32'd0; end
        3: begin sx = 1; sy = 256; end
        5: begin sx = 511; sy = 300; end
        7: begin ox = 32'h7FF00000; oy = 32'h7FF00000; csz = 32'hFFFFFFFF; end
        default: if (pick == 0) begin sx = $urandom_range(17, 64); sy = 2; end
      endcase
      set_map(ox, oy, inv, csz, sx[8:0], sy[8:0]);
      for (int n = 0; n < 155; n++)
        add_req(rand_req(used_x() * used_y() <= 1024));
      wait_drained();
    end
    calm = 0;

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/ogud_pkg.sv
design/ogud_fifo.sv
design/ogud_front.sv
design/ogud_back.sv
design/occupancy_grid_update_decay_unit.sv
tb/tb.sv
